>>> rtl/core/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the matrix chain cost evaluator.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int DIM_W = 12;
  localparam int NAME_W = 5;
  localparam int COST_W = 48;
  localparam int PROD1_W = 2 * DIM_W;
  localparam int PROD2_W = 3 * DIM_W;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int NAME_COUNT_DEF = 26;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TOKEN = 1'b1;

  localparam logic [1:0] TK_NAME = 2'd0;
  localparam logic [1:0] TK_CLOSE = 2'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } shape_t;

  typedef struct packed {
    logic              mode;
    logic [NAME_W-1:0] name_index;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [1:0]        token_kind;
    logic              end_of_expression;
  } in_beat_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [1:0]        status;
  } out_beat_t;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_PREV,
    SEL_NEXT
  } cell_sel_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_MERGE
  } stk_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NAME,
    S_CLOSE,
    S_MUL,
    S_ACC,
    S_END
  } state_t;

endpackage

>>> rtl/core/mct_ram.sv
// ----------------------------------------------------------------------------
// mct_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module mct_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 26,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mct_cell.sv
// ----------------------------------------------------------------------------
// mct_cell
// One shape stack cell: holds a shape or takes one from a neighbor.
// ----------------------------------------------------------------------------
module mct_cell
  import mct_pkg::*;
(
  input  logic      clk,
  input  cell_sel_t sel,
  input  shape_t    from_prev,
  input  shape_t    from_next,
  output shape_t    shape
);

  shape_t shape_r;
  shape_t shape_nxt;

  always_comb begin
    case (sel)
      SEL_PREV: shape_nxt = from_prev;
      SEL_NEXT: shape_nxt = from_next;
      default:  shape_nxt = shape_r;
    endcase
  end

  always_ff @(posedge clk) begin
    shape_r <= shape_nxt;
  end

  assign shape = shape_r;

endmodule

>>> rtl/core/mct_stack.sv
// ----------------------------------------------------------------------------
// mct_stack
// Shape stack as a row of cells, top of stack in cell zero.
// ----------------------------------------------------------------------------
module mct_stack
  import mct_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk,
  input  stk_op_t op,
  input  shape_t  push_shape,
  output shape_t  top0,
  output shape_t  top1
);

  shape_t    cell_q [DEPTH];
  cell_sel_t cell_sel [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    shape_t prev_in;
    shape_t next_in;

    if (i == 0) begin : g_head
      assign prev_in = push_shape;
    end else begin : g_body
      assign prev_in = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_in = cell_q[i];
    end else begin : g_inner
      assign next_in = cell_q[i+1];
    end

    always_comb begin
      case (op)
        STK_PUSH:  cell_sel[i] = SEL_PREV;
        STK_MERGE: cell_sel[i] = (i == 0) ? SEL_PREV : SEL_NEXT;
        default:   cell_sel[i] = SEL_HOLD;
      endcase
    end

    mct_cell u_cell (
      .clk       (clk),
      .sel       (cell_sel[i]),
      .from_prev (prev_in),
      .from_next (next_in),
      .shape     (cell_q[i])
    );
  end

  assign top0 = cell_q[0];
  assign top1 = cell_q[1];

endmodule

>>> rtl/core/matrix_chain_cost_evaluator.sv
// sequencing from one accept to the next: a load beat stays in S_IDLE; a name token
// passes S_NAME and S_END, a close token S_CLOSE, S_MUL, S_ACC and S_END (S_CLOSE and
// S_END when it faults), ignored tokens and tokens after a fault S_END only; an end token
// also waits in S_END while the output register is full; one beat in work at a time;
// the close sequence (stack merge, two registered multiplies, saturating add) is longest
// reset: synchronous active low, clears state, table valid bits, pointer, cost, fault
// ----------------------------------------------------------------------------
// matrix_chain_cost_evaluator
// Dimension table and cell-chain shape stack that sum the scalar multiply
// cost of a parenthesized matrix chain, with saturation and fault status.
// ----------------------------------------------------------------------------
module matrix_chain_cost_evaluator
  import mct_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NAME_COUNT = NAME_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int AW = (NAME_COUNT > 1) ? $clog2(NAME_COUNT) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [SPW-1:0]      sp_r, sp_nxt;
  logic [COST_W-1:0]   cost_r, cost_nxt;
  logic [1:0]          fault_r, fault_nxt;
  logic                last_r, last_nxt;
  logic                hit_r, hit_nxt;
  logic [PROD1_W-1:0]  prod1_r, prod1_nxt;
  logic [PROD2_W-1:0]  prod2_r, prod2_nxt;
  logic [DIM_W-1:0]    rc_r, rc_nxt;
  logic [NAME_COUNT-1:0] tbl_valid_r, tbl_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;

  logic                accept;
  logic                in_range;
  logic [AW-1:0]       addr;
  logic                tbl_we;
  shape_t              tbl_wdata;
  shape_t              tbl_rdata;
  stk_op_t             stk_op;
  shape_t              push_shape;
  shape_t              top0;
  shape_t              top1;
  logic [COST_W:0]     sum_ext;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign addr = AW'(in_data.name_index);
  assign in_range = (32'(in_data.name_index) < NAME_COUNT);
  assign tbl_we = accept && (in_data.mode == MODE_LOAD) && in_range;
  assign tbl_wdata = '{rows: in_data.rows, cols: in_data.cols};
  assign sum_ext = {1'b0, cost_r} + (COST_W + 1)'(prod2_r);

  mct_ram #(
    .WIDTH ($bits(shape_t)),
    .DEPTH (NAME_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (addr),
    .wdata (tbl_wdata),
    .raddr (addr),
    .rdata (tbl_rdata)
  );

  mct_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .op         (stk_op),
    .push_shape (push_shape),
    .top0       (top0),
    .top1       (top1)
  );

  always_comb begin
    state_nxt = state_r;
    sp_nxt = sp_r;
    cost_nxt = cost_r;
    fault_nxt = fault_r;
    last_nxt = last_r;
    hit_nxt = hit_r;
    prod1_nxt = prod1_r;
    prod2_nxt = prod2_r;
    rc_nxt = rc_r;
    tbl_valid_nxt = tbl_valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    stk_op = STK_HOLD;
    push_shape = '0;

    if (tbl_we) begin
      tbl_valid_nxt[addr] = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.mode == MODE_TOKEN)) begin
          last_nxt = in_data.end_of_expression;
          hit_nxt = in_range && tbl_valid_r[addr];
          if (fault_r != ST_OK) begin
            state_nxt = S_END;
          end else begin
            case (in_data.token_kind)
              TK_NAME:  state_nxt = S_NAME;
              TK_CLOSE: state_nxt = S_CLOSE;
              default:  state_nxt = S_END;
            endcase
          end
        end
      end
      S_NAME: begin
        if (sp_r >= SPW'(STACK_DEPTH)) begin
          fault_nxt = ST_OVERFLOW;
        end else begin
          stk_op = STK_PUSH;
          push_shape = hit_r ? tbl_rdata : '0;
          sp_nxt = sp_r + SPW'(1);
        end
        state_nxt = S_END;
      end
      S_CLOSE: begin
        if (sp_r < SPW'(2)) begin
          fault_nxt = ST_UNDERFLOW;
          state_nxt = S_END;
        end else if (top1.cols != top0.rows) begin
          fault_nxt = ST_MISMATCH;
          state_nxt = S_END;
        end else begin
          stk_op = STK_MERGE;
          push_shape = '{rows: top1.rows, cols: top0.cols};
          sp_nxt = sp_r - SPW'(1);
          prod1_nxt = PROD1_W'(top1.rows) * PROD1_W'(top1.cols);
          rc_nxt = top0.cols;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod2_nxt = PROD2_W'(prod1_r) * PROD2_W'(rc_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cost_nxt = sum_ext[COST_W] ? '1 : sum_ext[COST_W-1:0];
        state_nxt = S_END;
      end
      S_END: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.cost = (fault_r == ST_OK) ? cost_r : '0;
          out_data_nxt.status = fault_r;
          sp_nxt = '0;
          cost_nxt = '0;
          fault_nxt = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r <= '0;
      cost_r <= '0;
      fault_r <= ST_OK;
      last_r <= 1'b0;
      tbl_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
      cost_r <= cost_nxt;
      fault_r <= fault_nxt;
      last_r <= last_nxt;
      tbl_valid_r <= tbl_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    prod1_r <= prod1_nxt;
    prod2_r <= prod2_nxt;
    rc_r <= rc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
